>>> sv/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Frame scheduler package
// Shared types, event and action codes, and sizing constants.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam logic [2:0] OP_FRAME_REQ  = 3'd0;
  localparam logic [2:0] OP_COMMIT     = 3'd1;
  localparam logic [2:0] OP_PRESENT    = 3'd2;
  localparam logic [2:0] OP_FEEDBACK   = 3'd3;
  localparam logic [2:0] OP_IDLE_FIRED = 3'd4;
  localparam logic [2:0] OP_TIMER_FIRED = 3'd5;

  localparam logic [1:0] IDLE_NONE    = 2'd0;
  localparam logic [1:0] IDLE_REQUEST = 2'd1;
  localparam logic [1:0] IDLE_CANCEL  = 2'd2;

  localparam logic [1:0] TIMER_LEAVE  = 2'd0;
  localparam logic [1:0] TIMER_DISARM = 2'd1;
  localparam logic [1:0] TIMER_ARM    = 2'd2;

  localparam logic [0:0] REG_MIN_MARGIN = 1'd0;
  localparam logic [0:0] REG_IDLE_THR   = 1'd1;

  localparam int FSC_QUEUE_DEPTH = 4;

  localparam logic [26:0] MIN_MARGIN_RST = 27'd1500000;
  localparam logic [26:0] IDLE_THR_RST   = 27'd1000000;
  localparam logic [31:0] RECIP_5        = 32'hCCCCCCCD;
  localparam logic [26:0] RECIP_MS       = 27'd70368745;
  localparam logic [11:0] TIMER_MS_MAX   = 12'd4095;
  localparam logic signed [65:0] SAT_NS  = 66'sd4096000000;
  localparam logic signed [65:0] MS_NS   = 66'sd1000000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               output_enabled;
    logic               presented;
    logic [29:0]        refresh_period_ns;
    logic [62:0]        present_time_ns;
    logic [62:0]        current_time_ns;
    logic signed [31:0] gpu_duration_ns;
    logic [29:0]        pre_render_ns;
    logic               gpu_timer_valid;
  } fsc_in_t;

  typedef struct packed {
    logic        frame_emitted;
    logic [1:0]  idle_action;
    logic [1:0]  timer_action;
    logic [11:0] timer_ms;
    logic [31:0] estimate_ns;
  } fsc_out_t;

  // Classified event as it waits in the queue.
  typedef struct packed {
    logic [2:0]         opcode;
    logic               output_enabled;
    logic               presented;
    logic [31:0]        gpu_duration_ns;
    logic [29:0]        pre_render_ns;
    logic               gpu_timer_valid;
    logic               refresh_zero;
    logic [26:0]        margin_ns;
    logic signed [64:0] slack_ns;
  } fsc_job_t;

endpackage

>>> sv/fsc_front.sv
// ----------------------------------------------------------------------------
// Frame scheduler front end
// Works out the state-free timing terms of an event before it is queued.
// ----------------------------------------------------------------------------
module fsc_front import fsc_pkg::*; (
  input  fsc_in_t     in_data,
  input  logic [26:0] min_margin,
  output fsc_job_t    job
);

  logic [59:0] prod;
  logic [25:0] fifth;
  logic [26:0] twentieth;

  // refresh / 20 = (refresh >> 2) / 5, the latter by reciprocal multiply.
  assign prod      = 60'(in_data.refresh_period_ns[29:2]) * 60'(RECIP_5);
  assign fifth     = prod[59:34];
  assign twentieth = {1'b0, fifth};

  always_comb begin
    job.opcode          = in_data.opcode;
    job.output_enabled  = in_data.output_enabled;
    job.presented       = in_data.presented;
    job.gpu_duration_ns = in_data.gpu_duration_ns;
    job.pre_render_ns   = in_data.pre_render_ns;
    job.gpu_timer_valid = in_data.gpu_timer_valid;
    job.refresh_zero    = (in_data.refresh_period_ns == 30'd0);
    job.margin_ns       = (twentieth < min_margin) ? min_margin : twentieth;
    job.slack_ns        = $signed({2'b00, in_data.present_time_ns})
                        + $signed({35'd0, in_data.refresh_period_ns})
                        - $signed({2'b00, in_data.current_time_ns});
  end

endmodule

>>> sv/fsc_queue.sv
// ----------------------------------------------------------------------------
// Frame scheduler event queue
// Small FIFO that decouples event intake from event execution.
// ----------------------------------------------------------------------------
module fsc_queue import fsc_pkg::*; #(
  parameter int DEPTH = FSC_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fsc_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output fsc_job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsc_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/fsc_div.sv
// ----------------------------------------------------------------------------
// Frame scheduler divider
// Constant divider by reciprocal multiply: divide by 5 or by one million.
// ----------------------------------------------------------------------------
module fsc_div import fsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        by_ms,
  input  logic [31:0] dividend,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] dvd_r;
  logic        by_ms_r;
  logic        busy_r;
  logic [31:0] quo_r;
  logic [63:0] prod_five;
  logic [52:0] prod_ms;

  // x / 5 = (x * ceil(2^34 / 5)) >> 34, exact for any 32-bit x.
  assign prod_five = 64'(dvd_r) * 64'(RECIP_5);
  // x / 1000000 = (x >> 6) / 15625; for a 26-bit operand the product with
  // ceil(2^40 / 15625) shifted down by 40 is exact.
  assign prod_ms   = 53'(dvd_r[31:6]) * 53'(RECIP_MS);

  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r   <= dividend;
      by_ms_r <= by_ms;
    end
    if (busy_r) begin
      quo_r <= by_ms_r ? {19'd0, prod_ms[52:40]} : {2'b00, prod_five[63:34]};
    end
  end

  // busy_r follows start; the quotient register loads while busy_r is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

endmodule

>>> sv/fsc_back.sv
// ----------------------------------------------------------------------------
// Frame scheduler back end
// Executes queued events against the scheduler state and issues results.
// ----------------------------------------------------------------------------
module fsc_back import fsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  fsc_job_t    q_data,
  output logic        q_pop,
  input  logic [26:0] idle_thr,
  output logic        out_valid,
  input  logic        out_ready,
  output fsc_out_t    out_data
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_EST = 3'b010,
    ST_MS  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic        fw_r, fw_nxt;
  logic        loop_r, loop_nxt;
  logic        idle_req_r, idle_req_nxt;
  logic [31:0] est_r, est_nxt;
  logic        est_valid_r, est_valid_nxt;
  logic [29:0] held_pre_r, held_pre_nxt;
  logic        held_tv_r, held_tv_nxt;
  logic        fb_wait_r, fb_wait_nxt;
  logic        out_valid_r, out_valid_nxt;
  fsc_out_t    out_data_r, out_data_nxt;

  logic              div_start, div_busy, div_by_ms;
  logic [31:0]       div_dvd, div_q;

  logic [30:0]        gpu_used;
  logic [31:0]        sample;
  logic [31:0]        avg_hi, avg_lo;
  logic [32:0]        gap_rnd;
  logic signed [65:0] delay;
  logic               is_pres, need_est, idle_pres, sat, under_ms, need_ms;
  logic               slot_free, do_item;
  fsc_out_t           res;

  fsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .by_ms    (div_by_ms),
    .dividend (div_dvd),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign gpu_used = (held_tv_r && q_data.gpu_duration_ns != 32'd0 && !q_data.gpu_duration_ns[31])
                  ? q_data.gpu_duration_ns[30:0] : 31'd0;
  assign sample   = {2'b00, held_pre_r} + {1'b0, gpu_used};
  // The weighted average moves the larger value toward the smaller one by
  // a tenth of their gap, rounded so the floor of the average results.
  assign avg_hi   = (sample > est_r) ? sample : est_r;
  assign avg_lo   = (sample > est_r) ? est_r : sample;
  assign gap_rnd  = {1'b0, avg_hi - avg_lo} + 33'd9;
  assign delay    = {q_data.slack_ns[64], q_data.slack_ns}
                  - $signed({34'd0, est_r}) - $signed({39'd0, q_data.margin_ns});

  assign is_pres   = (q_data.opcode == OP_PRESENT) && q_data.presented;
  assign need_est  = is_pres && fb_wait_r;
  assign idle_pres = !est_valid_r || q_data.refresh_zero
                  || (delay < $signed({39'd0, idle_thr}));
  assign sat       = (delay >= SAT_NS);
  assign under_ms  = (delay < MS_NS);
  assign need_ms   = is_pres && !idle_pres && !sat && !under_ms;
  assign slot_free = out_ready || !out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    fw_nxt        = fw_r;
    loop_nxt      = loop_r;
    idle_req_nxt  = idle_req_r;
    est_nxt       = est_r;
    est_valid_nxt = est_valid_r;
    held_pre_nxt  = held_pre_r;
    held_tv_nxt   = held_tv_r;
    fb_wait_nxt   = fb_wait_r;
    div_start     = 1'b0;
    div_by_ms     = 1'b0;
    div_dvd       = gap_rnd[32:1];
    do_item       = 1'b0;
    res           = '0;

    case (state_r)
      ST_RUN: begin
        if (q_valid) begin
          if (need_est) begin
            // Fold held render feedback into the estimate before timing.
            fb_wait_nxt = 1'b0;
            if (!est_valid_r) begin
              est_nxt       = sample;
              est_valid_nxt = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_EST;
            end
          end else if (need_ms) begin
            div_start = 1'b1;
            div_by_ms = 1'b1;
            div_dvd   = delay[31:0];
            state_nxt = ST_MS;
          end else if (slot_free) begin
            do_item = 1'b1;
          end
        end
      end
      ST_EST: begin
        if (!div_busy) begin
          est_nxt   = avg_hi - div_q;
          state_nxt = ST_RUN;
        end
      end
      ST_MS: begin
        if (!div_busy && slot_free) begin
          do_item   = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    if (do_item) begin
      case (q_data.opcode)
        OP_FRAME_REQ: begin
          fw_nxt = 1'b1;
          if (!idle_req_r && !loop_r) begin
            res.timer_action = TIMER_DISARM;
            res.idle_action  = IDLE_REQUEST;
            idle_req_nxt     = 1'b1;
          end
        end
        OP_COMMIT: begin
          if (q_data.output_enabled) begin
            loop_nxt         = 1'b1;
            res.timer_action = TIMER_DISARM;
            if (idle_req_r) begin
              idle_req_nxt    = 1'b0;
              res.idle_action = IDLE_CANCEL;
            end
          end
        end
        OP_PRESENT: begin
          if (!q_data.presented) begin
            loop_nxt = 1'b0;
          end else if (idle_pres) begin
            res.timer_action = TIMER_DISARM;
            if (!idle_req_r) begin
              idle_req_nxt    = 1'b1;
              res.idle_action = IDLE_REQUEST;
            end
          end else begin
            if (idle_req_r) begin
              idle_req_nxt    = 1'b0;
              res.idle_action = IDLE_CANCEL;
            end
            if (sat) begin
              res.timer_action = TIMER_ARM;
              res.timer_ms     = TIMER_MS_MAX;
            end else if (under_ms) begin
              res.timer_action = TIMER_DISARM;
            end else begin
              res.timer_action = TIMER_ARM;
              res.timer_ms     = div_q[11:0];
            end
          end
        end
        OP_FEEDBACK: begin
          held_pre_nxt = q_data.pre_render_ns;
          held_tv_nxt  = q_data.gpu_timer_valid;
          fb_wait_nxt  = 1'b1;
        end
        OP_IDLE_FIRED: begin
          if (idle_req_r) begin
            idle_req_nxt      = 1'b0;
            loop_nxt          = 1'b0;
            fw_nxt            = 1'b0;
            res.frame_emitted = fw_r;
          end
        end
        OP_TIMER_FIRED: begin
          loop_nxt          = 1'b0;
          fw_nxt            = 1'b0;
          res.frame_emitted = fw_r;
        end
        default: begin
        end
      endcase
      res.estimate_ns = est_r;
    end

    out_data_nxt  = do_item ? res : out_data_r;
    out_valid_nxt = do_item ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign q_pop     = do_item;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      fw_r        <= 1'b0;
      loop_r      <= 1'b0;
      idle_req_r  <= 1'b0;
      est_r       <= '0;
      est_valid_r <= 1'b0;
      held_pre_r  <= '0;
      held_tv_r   <= 1'b0;
      fb_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fw_r        <= fw_nxt;
      loop_r      <= loop_nxt;
      idle_req_r  <= idle_req_nxt;
      est_r       <= est_nxt;
      est_valid_r <= est_valid_nxt;
      held_pre_r  <= held_pre_nxt;
      held_tv_r   <= held_tv_nxt;
      fb_wait_r   <= fb_wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/predictive_frame_scheduler_core.sv
// ----------------------------------------------------------------------------
// Predictive frame scheduler core
// Event-driven frame-start scheduler with a render-time estimate.
// ----------------------------------------------------------------------------
// Usage: events enter on the in_ channel (valid/ready), one transfer per event,
// and each event yields exactly one result transfer on the out_ channel, in order.
// The cfg_ port writes the margin floor (index 0) and the idle threshold
// (index 1); write it only while no event is in flight.
// Throughput: the front end takes one event per cycle into a queue of
// QUEUE_DEPTH entries while the queue is not full. Each event passes through
// the queue and the output register; most events execute directly from ST_RUN.
// A shown present that takes its first render sample loads the estimate
// with it before timing; one that averages held feedback into the estimate
// waits in ST_EST for the reciprocal-multiply divider, and one that arms a
// timer below saturation waits in ST_MS for it as well.
// Reset (synchronous, active low) clears all flags, the estimate, the queue and
// the output valid flag, and restores the register defaults.
// When the receiver stalls, the finished result holds in the output register,
// the back end pops no further events, and the queue fills before in_ready drops.
// ----------------------------------------------------------------------------
module predictive_frame_scheduler_core import fsc_pkg::*; #(
  parameter int QUEUE_DEPTH = FSC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fsc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output fsc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [26:0] cfg_wdata
);

  logic [26:0] min_margin_r;
  logic [26:0] idle_thr_r;
  fsc_job_t    job, head;
  logic        q_full, q_valid, q_pop, push;

  // Configuration registers, written directly by the cfg_ port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_margin_r <= MIN_MARGIN_RST;
      idle_thr_r   <= IDLE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_MARGIN: min_margin_r <= cfg_wdata;
        REG_IDLE_THR:   idle_thr_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The front end computes the margin and the raw slack to the next vblank.
  fsc_front u_front (
    .in_data    (in_data),
    .min_margin (min_margin_r),
    .job        (job)
  );

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  fsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  // The back end owns the scheduler state and the output register.
  fsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (head),
    .q_pop     (q_pop),
    .idle_thr  (idle_thr_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/fsc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame scheduler checker
// Watches both channels, predicts each result from the accepted events and
// compares the result transfers against the predictions in order.
// ----------------------------------------------------------------------------
module fsc_checker import fsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  fsc_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  fsc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [26:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  logic [26:0] margin_floor;
  logic [26:0] idle_thr;
  logic        want_frame;
  logic        loop_on;
  logic        idle_out;
  logic [31:0] est;
  logic        est_ok;
  logic [29:0] fb_pre;
  logic        fb_gpu_ok;
  logic        fb_held;

  fsc_out_t expected_q[$];

  assign pending = expected_q.size();

  // Shown present: fold held feedback, then place the frame start.
  function automatic void schedule_present(input fsc_in_t ev, inout fsc_out_t r);
    logic [63:0] sample;
    logic [63:0] e;
    logic [63:0] margin;
    logic [65:0] lhs;
    logic [65:0] base;
    logic [65:0] ms;
    begin
      if (fb_held) begin
        fb_held = 1'b0;
        sample = {34'd0, fb_pre};
        if (fb_gpu_ok && ev.gpu_duration_ns > 0)
          sample += {32'd0, ev.gpu_duration_ns};
        e = {32'd0, est};
        if (!est_ok) begin
          e = sample;
          est_ok = 1'b1;
        end else if (sample > e) begin
          e = (9 * sample + e) / 10;
        end else begin
          e = (sample + 9 * e) / 10;
        end
        est = e[31:0];
      end
      if (!est_ok || ev.refresh_period_ns == 0) begin
        r.timer_action = TIMER_DISARM;
        if (!idle_out) begin
          idle_out = 1'b1;
          r.idle_action = IDLE_REQUEST;
        end
      end else begin
        margin = ev.refresh_period_ns / 20;
        if (margin < margin_floor) margin = margin_floor;
        lhs = ev.present_time_ns + ev.refresh_period_ns;
        base = ev.current_time_ns + est + margin;
        if (lhs < base + idle_thr) begin
          r.timer_action = TIMER_DISARM;
          if (!idle_out) begin
            idle_out = 1'b1;
            r.idle_action = IDLE_REQUEST;
          end
        end else begin
          ms = (lhs - base) / 1000000;
          if (idle_out) begin
            idle_out = 1'b0;
            r.idle_action = IDLE_CANCEL;
          end
          if (ms == 0) begin
            r.timer_action = TIMER_DISARM;
          end else begin
            r.timer_action = TIMER_ARM;
            r.timer_ms = (ms > 4095) ? TIMER_MS_MAX : ms[11:0];
          end
        end
      end
    end
  endfunction

  function automatic fsc_out_t predict_event(input fsc_in_t ev);
    fsc_out_t r;
    begin
      r = '0;
      case (ev.opcode)
        OP_FRAME_REQ: begin
          want_frame = 1'b1;
          if (!idle_out && !loop_on) begin
            r.timer_action = TIMER_DISARM;
            idle_out = 1'b1;
            r.idle_action = IDLE_REQUEST;
          end
        end
        OP_COMMIT: begin
          if (ev.output_enabled) begin
            loop_on = 1'b1;
            if (idle_out) begin
              idle_out = 1'b0;
              r.idle_action = IDLE_CANCEL;
            end
            r.timer_action = TIMER_DISARM;
          end
        end
        OP_PRESENT: begin
          if (!ev.presented) loop_on = 1'b0;
          else schedule_present(ev, r);
        end
        OP_FEEDBACK: begin
          fb_pre = ev.pre_render_ns;
          fb_gpu_ok = ev.gpu_timer_valid;
          fb_held = 1'b1;
        end
        OP_IDLE_FIRED: begin
          if (idle_out) begin
            idle_out = 1'b0;
            loop_on = 1'b0;
            r.frame_emitted = want_frame;
            want_frame = 1'b0;
          end
        end
        OP_TIMER_FIRED: begin
          loop_on = 1'b0;
          r.frame_emitted = want_frame;
          want_frame = 1'b0;
        end
        default: ;
      endcase
      r.estimate_ns = est;
      return r;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      margin_floor = MIN_MARGIN_RST;
      idle_thr = IDLE_THR_RST;
      want_frame = 1'b0;
      loop_on = 1'b0;
      idle_out = 1'b0;
      est = '0;
      est_ok = 1'b0;
      fb_pre = '0;
      fb_gpu_ok = 1'b0;
      fb_held = 1'b0;
      errors <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIN_MARGIN) margin_floor = cfg_wdata;
        else idle_thr = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors <= errors + 1;
        end else if (out_data !== expected_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, expected_q[0], out_data);
          errors <= errors + 1;
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_event(in_data));
    end
  end

endmodule

>>> test/tb_predictive_frame_scheduler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame scheduler testbench
// Drives directed and random event streams with random gaps and stalls
// through several register settings; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_predictive_frame_scheduler_core;
  import fsc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  fsc_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  fsc_out_t    out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [26:0] cfg_wdata;
  int          errors;
  int          pending;
  int          burst_left;
  int          stall_mode;

  predictive_frame_scheduler_core dut (.*);

  fsc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls on a slowly changing pattern: some stretches never
  // stall, some stall now and then, some stall most of the time.
  initial begin
    out_ready = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 15) < 4);
      endcase
    end
  end

  // Builds one event. Times are kept near each other most of the time so that
  // the timer path and the idle path both occur; the rest is wide noise.
  function automatic fsc_in_t make_event(input logic [2:0] op);
    fsc_in_t ev;
    logic [62:0] now;
    begin
      ev = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      ev.opcode = op;
      if ($urandom_range(0, 7) != 0) begin
        now = 63'({$urandom, $urandom});
        if ($urandom_range(0, 1)) now[62:50] = '0;
        ev.current_time_ns = now;
        ev.present_time_ns = now - 63'($urandom_range(0, 20000000))
                           + 63'($urandom_range(0, 8000000));
        ev.refresh_period_ns = $urandom_range(0, 5) == 0 ? 30'd0 :
                               $urandom_range(0, 1) ? 30'($urandom_range(4000000, 40000000)) :
                               30'($urandom_range(1, 30'h3FFFFFFF));
        ev.gpu_duration_ns = $urandom_range(0, 3) == 0 ? $signed($urandom) :
                             $urandom_range(0, 12000000);
        ev.pre_render_ns = $urandom_range(0, 3) == 0 ? 30'($urandom)
                                                     : 30'($urandom_range(0, 9000000));
      end
      return ev;
    end
  endfunction

  // One transfer: a random gap between bursts, then hold valid until accepted.
  task automatic send_event(input fsc_in_t ev);
    begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      in_valid <= 1'b1;
      in_data <= ev;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  // Registers change only with the block drained; the extra idle cycles
  // are a plain safety margin before the write.
  task automatic write_reg(input logic [0:0] idx, input logic [26:0] val);
    begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      repeat (100) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // A well-formed frame cycle with random content, or a random event.
  task automatic random_phase(input int count);
    int k;
    logic [2:0] op;
    begin
      for (k = 0; k < count; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          case (k % 6)
            0: op = OP_FRAME_REQ;
            1: op = $urandom_range(0, 1) ? OP_IDLE_FIRED : OP_TIMER_FIRED;
            2: op = OP_COMMIT;
            3: op = OP_FEEDBACK;
            4: op = OP_PRESENT;
            default: op = $urandom_range(0, 1) ? OP_TIMER_FIRED : OP_IDLE_FIRED;
          endcase
        end else begin
          op = 3'($urandom_range(0, 7));
        end
        send_event(make_event(op));
      end
    end
  endtask

  initial begin
    fsc_in_t ev;
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_MARGIN;
    cfg_wdata = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every opcode including the unused ones, stray idle fire,
    // present with no estimate, unknown refresh, not shown, disabled commit,
    // negative and zero GPU time, and field extremes.
    send_event(make_event(OP_IDLE_FIRED));
    send_event(make_event(OP_FRAME_REQ));
    ev = make_event(OP_COMMIT); ev.output_enabled = 1'b0; send_event(ev);
    ev = make_event(OP_COMMIT); ev.output_enabled = 1'b1; send_event(ev);
    ev = make_event(OP_PRESENT); ev.presented = 1'b1; send_event(ev);
    ev = make_event(OP_PRESENT); ev.presented = 1'b0; send_event(ev);
    ev = make_event(OP_FEEDBACK); ev.pre_render_ns = '1; ev.gpu_timer_valid = 1'b1;
    send_event(ev);
    ev = make_event(OP_PRESENT); ev.presented = 1'b1; ev.gpu_duration_ns = 32'sh7FFFFFFF;
    ev.refresh_period_ns = '1; ev.present_time_ns = '1; ev.current_time_ns = '0;
    send_event(ev);
    ev = make_event(OP_FEEDBACK); ev.pre_render_ns = '0; ev.gpu_timer_valid = 1'b1;
    send_event(ev);
    ev = make_event(OP_PRESENT); ev.presented = 1'b1; ev.gpu_duration_ns = 32'sh80000000;
    ev.refresh_period_ns = '0; send_event(ev);
    ev = make_event(OP_FEEDBACK); ev.gpu_timer_valid = 1'b0; send_event(ev);
    ev = make_event(OP_PRESENT); ev.presented = 1'b1; ev.gpu_duration_ns = 0;
    ev.present_time_ns = '0; ev.current_time_ns = '1; send_event(ev);
    send_event(make_event(OP_TIMER_FIRED));
    send_event(make_event(3'd6));
    send_event(make_event(3'd7));
    send_event(make_event(OP_FRAME_REQ));
    send_event(make_event(OP_IDLE_FIRED));

    // Random phases under different register settings, extremes included.
    random_phase(200);
    write_reg(REG_MIN_MARGIN, 27'd0);
    write_reg(REG_IDLE_THR, 27'd0);
    random_phase(200);
    write_reg(REG_MIN_MARGIN, 27'd100000000);
    write_reg(REG_IDLE_THR, 27'd100000000);
    random_phase(150);
    write_reg(REG_MIN_MARGIN, 27'h7FFFFFF);
    write_reg(REG_IDLE_THR, 27'h7FFFFFF);
    random_phase(50);
    for (i = 0; i < 2; i++) begin
      write_reg(REG_MIN_MARGIN, 27'($urandom_range(0, 3000000)));
      write_reg(REG_IDLE_THR, 27'($urandom_range(0, 3000000)));
      random_phase(100);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
